>>> sv/tit_pkg.sv
package tit_pkg;

  localparam int unsigned MinWidth   = 16;
  localparam int unsigned DblWidth   = 5;
  localparam int unsigned IntvWidth  = 32;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CntWidth   = 5;

  localparam logic [MinWidth-1:0] INTERVAL_MIN_RESET  = 16'd8;
  localparam logic [DblWidth-1:0] MAX_DOUBLINGS_RESET = 5'd16;
  localparam logic [DblWidth-1:0] DOUBLINGS_LIMIT     = 5'd16;
  localparam logic [CntWidth-1:0] DIV_LAST_STEP       = 5'd31;

  localparam logic REG_INTERVAL_MIN  = 1'b0;
  localparam logic REG_MAX_DOUBLINGS = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK        = 2'd0,
    CMD_COND_RESET  = 2'd1,
    CMD_FORCE_RESET = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]           command;
    logic [IntvWidth-1:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic                 send_now;
    logic                 running;
    logic [IntvWidth-1:0] current_interval;
    logic [IntvWidth-1:0] chosen_interval;
    logic [IntvWidth-1:0] time_left;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic eval;
    logic div_init;
    logic div_step;
    logic finish;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic pick;
    logic half_zero;
    logic div_last;
  } sts_t;

endpackage

>>> sv/tit_if.sv
interface tit_in_if import tit_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tit_out_if import tit_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/tit_datapath.sv
module tit_datapath import tit_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CfgWidth-1:0]  cfg_data_i,
  input  in_item_t             item_i,
  input  ctl_t                 ctl_i,
  output sts_t                 sts_o,
  output out_item_t            rsp_o
);

  logic [MinWidth-1:0]  min_q;
  logic [DblWidth-1:0]  dbl_q;
  logic [1:0]           cmd_q;
  logic                 active_q, active_d;
  logic                 send_q, send_d;
  logic [IntvWidth-1:0] cur_q, cur_d;
  logic [IntvWidth-1:0] picked_q, picked_d;
  logic [IntvWidth-1:0] cd_q, cd_d;
  logic [IntvWidth-1:0] rem_q, rem_d;
  logic [IntvWidth-1:0] shf_q, shf_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  out_item_t            rsp_q;

  logic [DblWidth-1:0]  dcl;
  logic [IntvWidth-1:0] cap;
  logic [IntvWidth:0]   dbl33;
  logic [IntvWidth-1:0] grown;
  logic [IntvWidth-1:0] cd_dec;
  logic [IntvWidth-1:0] half;
  logic [IntvWidth-1:0] rem_sh;
  logic [IntvWidth-1:0] min32;
  logic                 pick;

  assign min32  = {{(IntvWidth-MinWidth){1'b0}}, min_q};
  assign dcl    = (dbl_q > DOUBLINGS_LIMIT) ? DOUBLINGS_LIMIT : dbl_q;
  assign cap    = min32 << dcl;
  assign dbl33  = {cur_q, 1'b0};
  assign grown  = (dbl33 < {1'b0, cap}) ? dbl33[IntvWidth-1:0] : cap;
  assign cd_dec = (cd_q != '0) ? cd_q - 1'b1 : '0;
  assign half   = {1'b0, cur_q[IntvWidth-1:1]};
  assign rem_sh = {rem_q[IntvWidth-2:0], shf_q[IntvWidth-1]};

  always_comb begin
    active_d = active_q;
    send_d   = send_q;
    cur_d    = cur_q;
    picked_d = picked_q;
    cd_d     = cd_q;
    rem_d    = rem_q;
    shf_d    = shf_q;
    cnt_d    = cnt_q;
    pick     = 1'b0;
    case (cmd_e'(cmd_q))
      CMD_TICK: begin
        if (active_q && cd_dec == '0) begin
          pick = 1'b1;
        end
      end
      CMD_COND_RESET: begin
        pick = !active_q || (cur_q > min32);
      end
      CMD_FORCE_RESET: begin
        pick = 1'b1;
      end
      default: begin
        pick = 1'b0;
      end
    endcase
    if (ctl_i.eval) begin
      send_d = 1'b0;
      if (cmd_e'(cmd_q) == CMD_TICK) begin
        if (active_q) begin
          cd_d = cd_dec;
          if (pick) begin
            send_d = 1'b1;
            cur_d  = grown;
          end
        end
      end else if (pick) begin
        cur_d    = min32;
        active_d = 1'b1;
      end
    end
    // hold the draw of the accepted request for the divider
    if (ctl_i.load_item) begin
      shf_d = item_i.random_value;
    end
    if (ctl_i.div_init) begin
      rem_d = '0;
      cnt_d = '0;
    end
    if (ctl_i.div_step) begin
      // restoring step: one quotient bit per cycle, keep the remainder only
      rem_d = (rem_sh >= half) ? rem_sh - half : rem_sh;
      shf_d = {shf_q[IntvWidth-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
    end
    if (ctl_i.finish) begin
      picked_d = cur_q - rem_q;
      cd_d     = cur_q - rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= INTERVAL_MIN_RESET;
      dbl_q    <= MAX_DOUBLINGS_RESET;
      active_q <= 1'b0;
      cur_q    <= '0;
      picked_q <= '0;
      cd_q     <= '0;
      send_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_INTERVAL_MIN) begin
          min_q <= cfg_data_i[MinWidth-1:0];
        end else begin
          dbl_q <= cfg_data_i[DblWidth-1:0];
        end
      end
      active_q <= active_d;
      cur_q    <= cur_d;
      picked_q <= picked_d;
      cd_q     <= cd_d;
      send_q   <= send_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    shf_q <= shf_d;
    if (ctl_i.load_item) begin
      cmd_q <= item_i.command;
    end
    if (ctl_i.load_out) begin
      rsp_q.send_now         <= send_q;
      rsp_q.running          <= active_q;
      rsp_q.current_interval <= cur_q;
      rsp_q.chosen_interval  <= picked_q;
      rsp_q.time_left        <= cd_q;
    end
  end

  assign sts_o.pick      = pick;
  assign sts_o.half_zero = (half == '0);
  assign sts_o.div_last  = (cnt_q == DIV_LAST_STEP);
  assign rsp_o           = rsp_q;

  a_finish_loads_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.finish |=> cd_q == picked_q)
    else $error("countdown not reloaded with chosen interval");

  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.finish |=> picked_q <= cur_q)
    else $error("chosen interval above current interval");

  a_send_needs_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    send_q |-> active_q)
    else $error("send flagged on a stopped timer");

endmodule

>>> sv/tit_ctrl.sv
module tit_ctrl import tit_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PREP,
    S_DIV,
    S_FIN,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   emit_go;

  assign emit_go = !out_valid_q || rsp_ready_i;

  always_comb begin
    ctl_o           = '0;
    ctl_o.load_item = (state_q == S_IDLE) && req_valid_i;
    ctl_o.eval      = (state_q == S_EVAL);
    ctl_o.div_init  = (state_q == S_EVAL);
    ctl_o.div_step  = (state_q == S_DIV);
    ctl_o.finish    = (state_q == S_FIN);
    ctl_o.load_out  = (state_q == S_EMIT) && emit_go;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_EMIT && emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) state_q <= S_EVAL;
        end
        S_EVAL: begin
          state_q <= sts_i.pick ? S_PREP : S_EMIT;
        end
        S_PREP: begin
          // skip the divider when half the interval is zero
          state_q <= sts_i.half_zero ? S_FIN : S_DIV;
        end
        S_DIV: begin
          if (sts_i.div_last) state_q <= S_FIN;
        end
        S_FIN: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && sts_i.div_last) |=> state_q == S_FIN)
    else $error("divider did not hand over to finish");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("response raised outside emit");

  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_valid_q && !rsp_ready_i) |=> state_q == S_EMIT)
    else $error("response overwritten before taken");

endmodule

>>> sv/trickle_interval_timer_core.sv
// A request goes from IDLE to EVAL, then to EMIT when no new interval is picked;
// else to PREP, then to FIN through the bit-serial remainder unit in DIV (skipped
// when half the interval is zero), then to EMIT. One request at a time; the next
// request is taken the cycle after the response is loaded into the output register.
// Reset (asynchronous, active low): timer stopped, intervals and countdown 0,
// interval_min 8, max_doublings 16, no response pending.
module trickle_interval_timer_core import tit_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_data_i,
  tit_in_if.sink              req_i,
  tit_out_if.source           rsp_o
);

  ctl_t      ctl;
  sts_t      sts;
  out_item_t rsp_data;
  logic      req_ready;
  logic      rsp_valid;

  tit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  tit_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (req_i.data),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .rsp_o      (rsp_data)
  );

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;
  assign rsp_o.data  = rsp_data;

endmodule
